FILE: hdl/marker_delimited_deframer_unit_macros.svh
// Assertion macros shared by the marker delimited deframer.
`ifndef MARKER_DELIMITED_DEFRAMER_UNIT_MACROS_SVH
`define MARKER_DELIMITED_DEFRAMER_UNIT_MACROS_SVH

// Checked only outside reset.
`define MDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define MDD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/mdd_pkg.sv
// Package with marker tables and result codes for the marker delimited deframer.
`timescale 1ns / 1ps

package mdd_pkg;

  localparam int MARKER_MAX = 32;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PAYLOAD = 2'd0;
  localparam kind_t KIND_END     = 2'd1;
  localparam kind_t KIND_DROP    = 2'd2;

  localparam logic [15:0] FRAME_LIMIT_RESET = 16'd4096;

  localparam logic [7:0] HEAD_MARKER [MARKER_MAX] = '{
    8'h49, 8'h50, 8'h43, 8'h45, 8'h56, 8'h45, 8'h4E, 8'h54,
    8'h5F, 8'h44, 8'h41, 8'h54, 8'h41, 8'h48, 8'h45, 8'h41,
    8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] TAIL_MARKER [MARKER_MAX] = '{
    8'h49, 8'h50, 8'h43, 8'h45, 8'h56, 8'h45, 8'h4E, 8'h54,
    8'h5F, 8'h44, 8'h41, 8'h54, 8'h41, 8'h54, 8'h41, 8'h49,
    8'h4C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

FILE: hdl/marker_delimited_deframer_unit.sv
// Top level of the marker delimited deframer: head/tail marker search and payload release.
`timescale 1ns / 1ps

// Unless stalled, the block takes one byte per cycle and returns at most one result each.
// While hunting it drops bytes until the last MARKER_LEN bytes equal the head marker.
// Inside a frame every byte passes through a MARKER_LEN-byte holdback window, so a byte
// is released as payload only once the window is full and does not hold the tail marker.
// A tail match reports the frame end with the payload length; a frame that reaches
// max_frame_bytes is reported as dropped. The sustained rate is one byte per cycle
// while the sink does not stall. A byte sits in the input register, the parallel
// marker compares run between that register and the result register, and its result
// is presented on the output from the result register.
// A result that waits for the sink keeps the byte behind it in the input register, and
// further bytes are stalled until the sink takes the waiting result.
// The limit register may be written only while the block is idle.
module marker_delimited_deframer_unit
  import mdd_pkg::*;
#(
  parameter int MARKER_LEN = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] max_frame_bytes,
  output logic        result_valid,
  input  logic        result_stall,
  output kind_t       kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_length
);

  localparam int WinW = MARKER_LEN * 8;
  localparam int CntW = $clog2(MARKER_LEN + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(MARKER_LEN);
  localparam logic [17:0] LimitBias = 18'(MARKER_LEN + 1);

  logic [15:0]     frame_limit;
  logic            in_frame;
  logic [WinW-1:0] history;
  logic [CntW-1:0] history_fill;
  logic [CntW-1:0] held_count;
  logic [15:0]     payload_received;

  logic            stage_valid;
  logic [7:0]      stage_byte;

  logic            result_ready;
  logic            stage_fire;
  logic            data_accept;

  logic [WinW+7:0] window_ext;
  logic [WinW-1:0] window_next;
  logic            head_match;
  logic            tail_match;
  logic            limit_hit;
  logic [CntW-1:0] fill_inc;
  logic [CntW-1:0] held_inc;

  logic            in_frame_next;
  logic [WinW-1:0] history_next;
  logic [CntW-1:0] history_fill_next;
  logic [CntW-1:0] held_count_next;
  logic [15:0]     payload_received_next;
  logic            emit;
  kind_t           kind_next;
  logic [7:0]      payload_byte_next;
  logic [15:0]     payload_length_next;

  assign cfg_ready    = 1'b1;
  assign result_ready = !result_valid || !result_stall;
  assign stage_fire   = stage_valid && result_ready;
  assign data_stall   = stage_valid && !result_ready;
  assign data_accept  = data_valid && !data_stall;

  assign window_ext  = {stage_byte, history};
  assign window_next = window_ext[WinW+7:8];

  always_comb begin
    head_match = 1'b1;
    tail_match = 1'b1;
    for (int i = 0; i < MARKER_LEN; i++) begin
      if (window_next[i*8 +: 8] != HEAD_MARKER[i]) begin
        head_match = 1'b0;
      end
      if (window_next[i*8 +: 8] != TAIL_MARKER[i]) begin
        tail_match = 1'b0;
      end
    end
  end

  assign fill_inc  = (history_fill == FullCnt) ? FullCnt : history_fill + 1'b1;
  assign held_inc  = (held_count == FullCnt) ? FullCnt : held_count + 1'b1;
  assign limit_hit = ({2'b00, payload_received} + LimitBias) >= {2'b00, frame_limit};

  always_comb begin
    in_frame_next         = in_frame;
    history_next          = window_next;
    history_fill_next     = history_fill;
    held_count_next       = held_count;
    payload_received_next = payload_received;
    emit                  = 1'b0;
    kind_next             = KIND_PAYLOAD;
    payload_byte_next     = 8'd0;
    payload_length_next   = 16'd0;
    if (!in_frame) begin
      if (fill_inc == FullCnt && head_match) begin
        in_frame_next         = 1'b1;
        history_next          = '0;
        history_fill_next     = '0;
        held_count_next       = '0;
        payload_received_next = 16'd0;
      end else begin
        history_fill_next = fill_inc;
      end
    end else if (held_inc != FullCnt) begin
      held_count_next = held_inc;
    end else if (tail_match || limit_hit) begin
      emit                  = 1'b1;
      kind_next             = tail_match ? KIND_END : KIND_DROP;
      payload_length_next   = tail_match ? payload_received : 16'd0;
      in_frame_next         = 1'b0;
      history_next          = '0;
      history_fill_next     = '0;
      held_count_next       = '0;
      payload_received_next = 16'd0;
    end else begin
      emit                  = 1'b1;
      kind_next             = KIND_PAYLOAD;
      payload_byte_next     = window_next[7:0];
      held_count_next       = held_inc;
      payload_received_next = payload_received + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= FRAME_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_limit <= max_frame_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (data_accept) begin
      stage_valid <= 1'b1;
    end else if (stage_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_accept) begin
      stage_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame         <= 1'b0;
      history          <= '0;
      history_fill     <= '0;
      held_count       <= '0;
      payload_received <= 16'd0;
    end else if (stage_fire) begin
      in_frame         <= in_frame_next;
      history          <= history_next;
      history_fill     <= history_fill_next;
      held_count       <= held_count_next;
      payload_received <= payload_received_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_ready) begin
      result_valid <= stage_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (result_ready && stage_fire && emit) begin
      kind           <= kind_next;
      payload_byte   <= payload_byte_next;
      payload_length <= payload_length_next;
    end
  end

`include "marker_delimited_deframer_unit_macros.svh"

  `MDD_ASSERT_ALWAYS(a_reset_clears, rst |=> !result_valid && !in_frame && !stage_valid, "reset did not clear the control state")
  `MDD_ASSERT(a_counts_bounded, history_fill <= FullCnt && held_count <= FullCnt, "window count beyond marker length")
  `MDD_ASSERT(a_hunt_no_hold, !in_frame |-> held_count == '0 && payload_received == 16'd0, "frame counters active while hunting")
  `MDD_ASSERT(a_result_needs_frame, stage_fire && emit |-> in_frame && held_inc == FullCnt, "result produced outside a full frame window")

endmodule
